// ===== rtl/tsde_pkg.sv =====
// tsde_pkg: shared types, constants and tables for the transient shaper
// used by every module of the block; no dependencies

package tsde_pkg;

  localparam int unsigned N_CH     = 8;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned AMT_W    = 17;
  localparam int unsigned DB_W     = 14;
  localparam int unsigned COEF_W   = 24;
  localparam int unsigned GAIN_W   = 31;
  localparam int unsigned ACC_W    = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = N_CH * SAMPLE_W;
  localparam int unsigned OUT_FLD_W  = N_CH * SAMPLE_W + 2 * AMT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // full scale sample and the divider offset (0.01 of full scale)
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] EPS_OFFSET =
    SAMPLE_W'(((64'd1 << (SAMPLE_W - 1)) + 64'd50) / 64'd100);
  localparam logic [AMT_W-1:0] AMOUNT_ONE = AMT_W'(65536);
  // log2(10)/20 in Q0.24
  localparam logic [21:0] LOG2_10_OVER_20 = 22'd2786634;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_DB    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_DB   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_ATTACK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_RELEASE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_ATTACK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_RELEASE = 3'd6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W-1:0]        mag_t;

  typedef struct packed {
    logic signed [DB_W-1:0] attack_db;
    logic signed [DB_W-1:0] sustain_db;
    logic [3:0]             channels;
    logic [COEF_W-1:0]      fast_attack;
    logic [COEF_W-1:0]      fast_release;
    logic [COEF_W-1:0]      slow_attack;
    logic [COEF_W-1:0]      slow_release;
  } cfg_t;

  // result of one frame's envelope and gain work
  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain;
    logic [AMT_W-1:0]  amount;
    logic [AMT_W-1:0]  block_peak;
  } core_st_t;

  // 2^(2^-(k+1)) in Q1.30
  function automatic logic [ACC_W-1:0] pow2_frac(input logic [3:0] k);
    logic [ACC_W-1:0] v;
    case (k)
      4'd0:    v = 31'd1518500250;
      4'd1:    v = 31'd1276901417;
      4'd2:    v = 31'd1170923762;
      4'd3:    v = 31'd1121280435;
      4'd4:    v = 31'd1097253708;
      4'd5:    v = 31'd1085434106;
      4'd6:    v = 31'd1079572136;
      4'd7:    v = 31'd1076653033;
      4'd8:    v = 31'd1075196443;
      4'd9:    v = 31'd1074468888;
      4'd10:   v = 31'd1074105294;
      4'd11:   v = 31'd1073923544;
      4'd12:   v = 31'd1073832680;
      4'd13:   v = 31'd1073787251;
      4'd14:   v = 31'd1073764537;
      default: v = 31'd1073753181;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tsde_lane.sv =====
// tsde_lane: one channel lane, magnitude for the peak search and gain scaling
// depends on tsde_pkg

module tsde_lane import tsde_pkg::*; (
  input  logic              clk_i,
  input  sample_t           sample_i,
  input  logic              active_i,
  input  logic [GAIN_W-1:0] gain_i,
  input  logic              load_i,
  output mag_t              mag_o,
  output sample_t           shaped_o
);

  logic [SAMPLE_W:0]                 abs_w;
  logic signed [SAMPLE_W+GAIN_W:0]   prod_w;
  logic signed [SAMPLE_W+GAIN_W:0]   rnd_w;
  logic signed [SAMPLE_W+GAIN_W-24:0] y_w;
  sample_t                           sat_w;
  sample_t                           shaped_q;

  // saturated magnitude, zero on an inactive channel
  always_comb begin
    abs_w = sample_i[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({sample_i[SAMPLE_W-1], sample_i}))
                                 : {1'b0, sample_i};
    if (!active_i) begin
      mag_o = '0;
    end else if (abs_w > {1'b0, FULL_SCALE}) begin
      mag_o = FULL_SCALE;
    end else begin
      mag_o = abs_w[SAMPLE_W-1:0];
    end
  end

  // scale by the Q.24 gain, round half up, saturate
  always_comb begin
    prod_w = $signed({{(GAIN_W+1){sample_i[SAMPLE_W-1]}}, sample_i})
           * $signed({{(SAMPLE_W+1){1'b0}}, gain_i});
    rnd_w  = prod_w + (SAMPLE_W+GAIN_W+1)'(1 << 23);
    y_w    = rnd_w[SAMPLE_W+GAIN_W:24];
    if (y_w > $signed({{(GAIN_W-23){1'b0}}, FULL_SCALE})) begin
      sat_w = sample_t'(FULL_SCALE);
    end else if (y_w < -$signed({{(GAIN_W-23){1'b0}}, FULL_SCALE}) - 1) begin
      sat_w = ~sample_t'(FULL_SCALE);
    end else begin
      sat_w = y_w[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      shaped_q <= active_i ? sat_w : '0;
    end
  end

  assign shaped_o = shaped_q;

endmodule

// ===== rtl/tsde_merge.sv =====
// tsde_merge: combines the lane magnitudes into the frame peak
// depends on tsde_pkg

module tsde_merge import tsde_pkg::*; (
  input  logic            clk_i,
  input  mag_t [N_CH-1:0] mag_i,
  input  logic            en_i,
  output mag_t            peak_o
);

  mag_t peak_q;
  mag_t max_w;

  // running maximum over the lanes
  always_comb begin
    max_w = '0;
    for (int k = 0; k < N_CH; k++) begin
      if (mag_i[k] > max_w) begin
        max_w = mag_i[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      peak_q <= max_w;
    end
  end

  assign peak_o = peak_q;

endmodule

// ===== rtl/tsde_core.sv =====
// tsde_core: envelope followers, transient divider, dB blend and dB-to-linear gain
// depends on tsde_pkg

module tsde_core import tsde_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     start_i,
  input  mag_t     peak_i,
  input  logic     last_i,
  output core_st_t st_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ENVF  = 4'd1;
  localparam logic [3:0] S_ENVS  = 4'd2;
  localparam logic [3:0] S_DSET  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_BLEND = 4'd5;
  localparam logic [3:0] S_EXP   = 4'd6;
  localparam logic [3:0] S_POW   = 4'd7;
  localparam logic [3:0] S_GAIN  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]              state_q, state_d;
  logic [3:0]              cnt_q;
  mag_t                    fast_q, slow_q;
  logic [AMT_W-1:0]        run_peak_q, amount_q, bpeak_q;
  logic [SAMPLE_W-1:0]     rem_q, den_q;
  logic signed [DB_W-1:0]  gdb_q;
  logic [15:0]             frac_q;
  logic signed [4:0]       n_q;
  logic [ACC_W-1:0]        acc_q;
  logic [GAIN_W-1:0]       gain_q;

  // shared envelope datapath
  logic                     sel_slow_w;
  mag_t                     env_w, env_new_w;
  logic [COEF_W-1:0]        coef_w;
  logic signed [SAMPLE_W:0] dif_w;
  logic signed [49:0]       eprod_w;
  logic signed [25:0]       step_w;
  logic signed [26:0]       sum_w;

  always_comb begin
    sel_slow_w = (state_q == S_ENVS);
    env_w      = sel_slow_w ? slow_q : fast_q;
    if (sel_slow_w) begin
      coef_w = (peak_i > env_w) ? cfg_i.slow_attack : cfg_i.slow_release;
    end else begin
      coef_w = (peak_i > env_w) ? cfg_i.fast_attack : cfg_i.fast_release;
    end
    dif_w   = $signed({1'b0, env_w}) - $signed({1'b0, peak_i});
    eprod_w = 50'(dif_w) * $signed({26'd0, coef_w});
    step_w  = 26'((eprod_w + 50'sd8388608) >>> 24);
    sum_w   = $signed({3'b000, peak_i}) + 27'(step_w);
    if (sum_w < 0) begin
      env_new_w = '0;
    end else if (sum_w > $signed({3'b000, FULL_SCALE})) begin
      env_new_w = FULL_SCALE;
    end else begin
      env_new_w = sum_w[SAMPLE_W-1:0];
    end
  end

  // divider step and set-up
  logic [SAMPLE_W:0]   rem2_w;
  logic                qbit_w;
  logic [SAMPLE_W-1:0] diff_w, dsum_w;
  always_comb begin
    rem2_w = {rem_q, 1'b0};
    qbit_w = rem2_w >= {1'b0, den_q};
    diff_w = fast_q - slow_q;
    dsum_w = slow_q + EPS_OFFSET;
  end

  // dB blend: sustain + (attack - sustain) * amount, rounded
  logic signed [DB_W:0]   ddb_w;
  logic signed [32:0]     bprod_w;
  logic signed [DB_W-1:0] gdb_w;
  logic [AMT_W-1:0]       newmax_w;
  always_comb begin
    ddb_w    = $signed({cfg_i.attack_db[DB_W-1], cfg_i.attack_db})
             - $signed({cfg_i.sustain_db[DB_W-1], cfg_i.sustain_db});
    bprod_w  = 33'(ddb_w) * $signed({16'd0, amount_q});
    gdb_w    = cfg_i.sustain_db + DB_W'((bprod_w + 33'sd32768) >>> 16);
    newmax_w = (amount_q > run_peak_q) ? amount_q : run_peak_q;
  end

  // exponent in Q.16 of log2
  logic signed [36:0] xprod_w;
  logic signed [20:0] e_w;
  always_comb begin
    xprod_w = 37'(gdb_q) * $signed({15'd0, LOG2_10_OVER_20});
    e_w     = 21'((xprod_w + 37'sd32768) >>> 16);
  end

  // fractional power, one table factor a cycle
  logic [61:0] pprod_w;
  always_comb begin
    pprod_w = 62'(acc_q) * 62'(pow2_frac(cnt_q)) + (62'd1 << 29);
  end

  // integer shift of the power
  logic signed [4:0] nc_w;
  logic [3:0]        sh_w;
  logic [ACC_W:0]    gsum_w;
  always_comb begin
    if (n_q > 5'sd5) begin
      nc_w = 5'sd5;
    end else if (n_q < -5'sd6) begin
      nc_w = -5'sd6;
    end else begin
      nc_w = n_q;
    end
    sh_w   = 4'(5'sd6 - nc_w);
    gsum_w = ({1'b0, acc_q} + ((ACC_W+1)'(1) << (sh_w - 4'd1))) >> sh_w;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = S_ENVF;
      S_ENVF:  state_d = S_ENVS;
      S_ENVS:  state_d = S_DSET;
      S_DSET: begin
        if (fast_q > slow_q && diff_w < dsum_w) begin
          state_d = S_DIV;
        end else begin
          state_d = S_BLEND;
        end
      end
      S_DIV:   if (cnt_q == 4'd15) state_d = S_BLEND;
      S_BLEND: state_d = S_EXP;
      S_EXP:   state_d = S_POW;
      S_POW:   if (cnt_q == 4'd15) state_d = S_GAIN;
      S_GAIN:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fast_q     <= '0;
      slow_q     <= '0;
      run_peak_q <= '0;
      cnt_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_ENVF: fast_q <= env_new_w;
        S_ENVS: slow_q <= env_new_w;
        S_DSET: cnt_q  <= '0;
        S_DIV:  cnt_q  <= cnt_q + 4'd1;
        S_BLEND: run_peak_q <= last_i ? '0 : newmax_w;
        S_EXP:  cnt_q  <= '0;
        S_POW:  cnt_q  <= cnt_q + 4'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_DSET: begin
        rem_q <= diff_w;
        den_q <= dsum_w;
        if (fast_q <= slow_q) begin
          amount_q <= '0;
        end else if (diff_w >= dsum_w) begin
          amount_q <= AMOUNT_ONE;
        end else begin
          amount_q <= '0;
        end
      end
      S_DIV: begin
        rem_q    <= qbit_w ? SAMPLE_W'(rem2_w - {1'b0, den_q}) : rem2_w[SAMPLE_W-1:0];
        amount_q <= {amount_q[AMT_W-2:0], qbit_w};
      end
      S_BLEND: begin
        gdb_q   <= gdb_w;
        bpeak_q <= last_i ? newmax_w : '0;
      end
      S_EXP: begin
        n_q    <= e_w[20:16];
        frac_q <= e_w[15:0];
        acc_q  <= ACC_W'(1) << 30;
      end
      S_POW: begin
        frac_q <= {frac_q[14:0], 1'b0};
        if (frac_q[15]) begin
          acc_q <= pprod_w[60:30];
        end
      end
      S_GAIN: gain_q <= gsum_w[GAIN_W-1:0];
      default: ;
    endcase
  end

  assign st_o.done       = (state_q == S_DONE);
  assign st_o.gain       = gain_q;
  assign st_o.amount     = amount_q;
  assign st_o.block_peak = bpeak_q;

endmodule

// ===== rtl/transient_shaper_dual_envelope.sv =====
// Transient shaper, fast/slow envelope, eight channel lanes. One frame is taken
// at a time: after an input transfer the 16-step restoring divider for the
// transient amount runs when the fast envelope exceeds the slow one by less than the
// divider offset margin allows a quotient below one, and is skipped otherwise; the
// 16-step fractional power loop of the dB-to-linear conversion follows, and both
// share one sequencer. The result is held on the output until taken and the next
// frame is accepted the cycle after. Configuration is written through a plain write port.
// depends on tsde_pkg, tsde_lane, tsde_merge, tsde_core

module transient_shaper_dual_envelope import tsde_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [COEF_W-1:0]       cfg_wdata_i,
  // input frames
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,   // sample_0 .. sample_7
  input  logic                    s_axis_tlast,   // block_last
  // output frames
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]   m_axis_tdata    // shaped_0 .. shaped_7,
                                                  // transient_level, block_peak_transient
);

  cfg_t                cfg_q;
  logic                busy_q, start_q, core_go_q, out_vld_q, last_q;
  sample_t [N_CH-1:0]  samples_q;
  mag_t    [N_CH-1:0]  mag_w;
  sample_t [N_CH-1:0]  shaped_w;
  logic    [N_CH-1:0]  active_w;
  mag_t                peak_w;
  core_st_t            st_w;
  logic [AMT_W-1:0]    level_q, bpeak_q;
  logic                in_xfer_w;

  assign in_xfer_w     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_db    <= '0;
      cfg_q.sustain_db   <= '0;
      cfg_q.channels     <= 4'd2;
      cfg_q.fast_attack  <= 24'd15728640;
      cfg_q.fast_release <= 24'd16765566;
      cfg_q.slow_attack  <= 24'd16765566;
      cfg_q.slow_release <= 24'd16776050;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ATTACK_DB:    cfg_q.attack_db    <= cfg_wdata_i[DB_W-1:0];
        REG_SUSTAIN_DB:   cfg_q.sustain_db   <= cfg_wdata_i[DB_W-1:0];
        REG_CHANNELS:     cfg_q.channels     <= cfg_wdata_i[3:0];
        REG_FAST_ATTACK:  cfg_q.fast_attack  <= cfg_wdata_i;
        REG_FAST_RELEASE: cfg_q.fast_release <= cfg_wdata_i;
        REG_SLOW_ATTACK:  cfg_q.slow_attack  <= cfg_wdata_i;
        REG_SLOW_RELEASE: cfg_q.slow_release <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // frame capture
  always_ff @(posedge clk_i) begin
    if (in_xfer_w) begin
      for (int k = 0; k < N_CH; k++) begin
        samples_q[k] <= s_axis_tdata[k*SAMPLE_W +: SAMPLE_W];
      end
      last_q <= s_axis_tlast;
    end
    if (st_w.done) begin
      level_q <= st_w.amount;
      bpeak_q <= st_w.block_peak;
    end
  end

  // control: busy from input transfer until output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      start_q   <= 1'b0;
      core_go_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      start_q   <= in_xfer_w;
      core_go_q <= start_q;
      if (in_xfer_w) begin
        busy_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        busy_q <= 1'b0;
      end
      if (st_w.done) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // channel lanes
  for (genvar k = 0; k < N_CH; k++) begin : g_lane
    assign active_w[k] = cfg_q.channels > 4'(k);
    tsde_lane u_lane (
      .clk_i    (clk_i),
      .sample_i (samples_q[k]),
      .active_i (active_w[k]),
      .gain_i   (st_w.gain),
      .load_i   (st_w.done),
      .mag_o    (mag_w[k]),
      .shaped_o (shaped_w[k])
    );
  end

  tsde_merge u_merge (
    .clk_i  (clk_i),
    .mag_i  (mag_w),
    .en_i   (start_q),
    .peak_o (peak_w)
  );

  tsde_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .start_i (core_go_q),
    .peak_i  (peak_w),
    .last_i  (last_q),
    .st_o    (st_w)
  );

  // output packing
  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < N_CH; k++) begin
      m_axis_tdata[k*SAMPLE_W +: SAMPLE_W] = shaped_w[k];
    end
    m_axis_tdata[N_CH*SAMPLE_W +: AMT_W]         = level_q;
    m_axis_tdata[N_CH*SAMPLE_W + AMT_W +: AMT_W] = bpeak_q;
  end

  assign m_axis_tvalid = out_vld_q;

endmodule

// ===== rtl/tsde_checker.sv =====
// tsde_checker: port-level checks on the transient shaper, bound to the top level
// depends on tsde_pkg and transient_shaper_dual_envelope

module tsde_checker import tsde_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [AMT_W-1:0] level_w, bpeak_w;
  assign level_w = m_axis_tdata[N_CH*SAMPLE_W +: AMT_W];
  assign bpeak_w = m_axis_tdata[N_CH*SAMPLE_W + AMT_W +: AMT_W];

  // one frame in flight: no input while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  // an input transfer makes the block busy
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready after input transfer");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // amount never above one
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (level_w <= AMOUNT_ONE && bpeak_w <= AMOUNT_ONE))
    else $error("transient amount out of range");

  // a reported block peak includes this frame
  a_peak_ge_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && bpeak_w != '0) |-> (bpeak_w >= level_w))
    else $error("block peak below frame amount");

endmodule

bind transient_shaper_dual_envelope tsde_checker u_tsde_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
